// ===== sv/tttt_pkg.sv =====
// Shared types and constants for the time-triggered task table.
package tttt_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int NRES_W        = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] PEND_MAX = 8'hFF;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_ADD      = 2'd1,
    REQ_DISPATCH = 2'd2,
    REQ_SPARE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_RUN  = 2'd2,
    STAT_NONE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_RD,
    ST_MOD,
    ST_END
  } state_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] countdown;
    logic [15:0] reload;
    logic [7:0]  pending;
  } entry_t;

  typedef struct packed {
    logic fire;
    logic free_slot;
  } upd_flags_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  slot;
    logic [7:0]  task_id;
  } result_t;

endpackage

// ===== sv/tttt_slot_upd.sv =====
// Per-slot update of one table entry for a tick or a dispatch.
module tttt_slot_upd (
  input  logic                dispatch,
  input  tttt_pkg::entry_t    ent_i,
  output tttt_pkg::entry_t    ent_o,
  output tttt_pkg::upd_flags_t flags_o
);

  always_comb begin
    ent_o   = ent_i;
    flags_o = '0;
    if (dispatch) begin
      if (ent_i.pending != 8'd0) begin
        flags_o.fire      = 1'b1;
        flags_o.free_slot = (ent_i.reload == 16'd0);
        ent_o.pending     = ent_i.pending - 8'd1;
      end
    end else if (ent_i.countdown == 16'd0) begin
      if (ent_i.pending != tttt_pkg::PEND_MAX) begin
        ent_o.pending = ent_i.pending + 8'd1;
      end
      if (ent_i.reload != 16'd0) begin
        ent_o.countdown = ent_i.reload;
      end
    end else begin
      ent_o.countdown = ent_i.countdown - 16'd1;
    end
  end

endmodule

// ===== sv/time_triggered_task_table.sv =====
// Top level of the time-triggered task table: sequencer, slot memory, result register.
//
//   channel  direction  handshake          beat
//   in_      into block in_valid/in_stall  req_type, task_id, first_delay, repeat_period
//   out_     out        out_valid/out_stall status, slot, run_task, last
//
// Tick and dispatch walk the slot memory: each used slot is read, then written
// back, and each free slot is skipped; the final beat of every request waits on
// out_stall, and a dispatch also holds a second due slot while a beat is stalled.
// Add scans the used flags one slot a cycle.
// Reset is synchronous; all slots come out free, no clearing pass.
// A new request is taken while the last result still sits in the output register.
module time_triggered_task_table #(
  parameter int NUM_SLOTS = tttt_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_task_id,
  input  logic [15:0] in_first_delay,
  input  logic [15:0] in_repeat_period,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_slot,
  output logic [7:0]  out_run_task,
  output logic        out_last
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  tttt_pkg::state_t  state_r, state_nxt;
  tttt_pkg::req_t    req_r, req_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [7:0]        task_r, task_nxt;
  logic [15:0]       delay_r, delay_nxt;
  logic [15:0]       period_r, period_nxt;
  tttt_pkg::result_t hold_r, hold_nxt;
  logic [tttt_pkg::NRES_W-1:0] nres_r, nres_nxt;
  logic [NUM_SLOTS-1:0] used_r, used_nxt;

  tttt_pkg::entry_t  mem [NUM_SLOTS];
  tttt_pkg::entry_t  rd_data_r;
  tttt_pkg::entry_t  mem_wdata;
  tttt_pkg::entry_t  upd_ent;
  tttt_pkg::upd_flags_t upd_flags;
  logic              mem_we;
  logic              rd_en;

  logic              out_valid_r;
  tttt_pkg::result_t out_res_r;
  logic              out_last_r;
  tttt_pkg::result_t emit_res;
  logic              emit;
  logic              emit_last;
  logic              out_free;
  logic              at_end;

  assign in_stall     = (state_r != tttt_pkg::ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_res_r.status;
  assign out_slot     = out_res_r.slot;
  assign out_run_task = out_res_r.task_id;
  assign out_last     = out_last_r;
  assign out_free     = !out_valid_r || !out_stall;
  assign at_end       = (idx_r == LAST_IDX);

  tttt_slot_upd u_upd (
    .dispatch (req_r == tttt_pkg::REQ_DISPATCH),
    .ent_i    (rd_data_r),
    .ent_o    (upd_ent),
    .flags_o  (upd_flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tttt_pkg::ST_IDLE;
      used_r  <= '0;
      nres_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      nres_r  <= nres_nxt;
    end
    req_r    <= req_nxt;
    idx_r    <= idx_nxt;
    task_r   <= task_nxt;
    delay_r  <= delay_nxt;
    period_r <= period_nxt;
    hold_r   <= hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (emit) begin
      out_res_r  <= emit_res;
      out_last_r <= emit_last;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    idx_nxt    = idx_r;
    task_nxt   = task_r;
    delay_nxt  = delay_r;
    period_nxt = period_r;
    hold_nxt   = hold_r;
    nres_nxt   = nres_r;
    used_nxt   = used_r;
    mem_we     = 1'b0;
    mem_wdata  = upd_ent;
    rd_en      = 1'b0;
    emit       = 1'b0;
    emit_res   = hold_r;
    emit_last  = 1'b0;

    unique case (state_r)
      tttt_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt    = tttt_pkg::req_t'(in_req_type);
          task_nxt   = in_task_id;
          delay_nxt  = in_first_delay;
          period_nxt = in_repeat_period;
          idx_nxt    = '0;
          nres_nxt   = '0;
          hold_nxt   = '{status: tttt_pkg::STAT_DONE, slot: 3'd0, task_id: 8'd0};
          unique case (tttt_pkg::req_t'(in_req_type))
            tttt_pkg::REQ_TICK:  state_nxt = tttt_pkg::ST_RD;
            tttt_pkg::REQ_ADD:   state_nxt = tttt_pkg::ST_FIND;
            tttt_pkg::REQ_DISPATCH: begin
              hold_nxt.status = tttt_pkg::STAT_NONE;
              state_nxt       = tttt_pkg::ST_RD;
            end
            default: state_nxt = tttt_pkg::ST_END;
          endcase
        end
      end

      tttt_pkg::ST_FIND: begin
        if (!used_r[idx_r]) begin
          used_nxt[idx_r] = 1'b1;
          mem_we          = 1'b1;
          mem_wdata       = '{task_id: task_r, countdown: delay_r, reload: period_r,
                              pending: 8'd0};
          hold_nxt.slot   = 3'(idx_r);
          state_nxt       = tttt_pkg::ST_END;
        end else if (at_end) begin
          hold_nxt.status = tttt_pkg::STAT_FULL;
          state_nxt       = tttt_pkg::ST_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      tttt_pkg::ST_RD: begin
        if (used_r[idx_r]) begin
          rd_en     = 1'b1;
          state_nxt = tttt_pkg::ST_MOD;
        end else if (at_end) begin
          state_nxt = tttt_pkg::ST_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      tttt_pkg::ST_MOD: begin
        // a second due slot pushes the held one out first
        if (!(upd_flags.fire && hold_r.status == tttt_pkg::STAT_RUN && !out_free)) begin
          mem_we = 1'b1;
          if (upd_flags.fire) begin
            emit     = (hold_r.status == tttt_pkg::STAT_RUN);
            hold_nxt = '{status: tttt_pkg::STAT_RUN, slot: 3'(idx_r),
                         task_id: rd_data_r.task_id};
            nres_nxt = nres_r + 1'b1;
            if (upd_flags.free_slot) begin
              used_nxt[idx_r] = 1'b0;
            end
          end
          if (at_end || nres_nxt == tttt_pkg::NRES_W'(tttt_pkg::MAX_RESULTS)) begin
            state_nxt = tttt_pkg::ST_END;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = tttt_pkg::ST_RD;
          end
        end
      end

      tttt_pkg::ST_END: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          state_nxt = tttt_pkg::ST_IDLE;
        end
      end

      default: state_nxt = tttt_pkg::ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_mod_used_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tttt_pkg::ST_MOD |-> used_r[idx_r])
    else $error("slot update on a free slot");

  a_nres_cap: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= tttt_pkg::NRES_W'(tttt_pkg::MAX_RESULTS))
    else $error("dispatch result count above cap");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tttt_pkg::ST_END && hold_r.status == tttt_pkg::STAT_FULL) |-> &used_r)
    else $error("table full reported with a free slot");

  a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tttt_pkg::ST_END && out_free) |=>
      (state_r == tttt_pkg::ST_IDLE && out_valid_r && out_last_r))
    else $error("final beat not followed by idle");
`endif

endmodule
